/* design/mtfzr_pkg.sv */
// Shared types and constants of the move-to-front zero-run coder.
package mtfzr_pkg;

  // Default geometry
  localparam int unsigned DefListDepth = 256;
  localparam int unsigned DefRunWidth  = 24;

  // Field widths fixed by the interface
  localparam int unsigned SymW   = 8;
  localparam int unsigned CountW = 9;
  localparam int unsigned ActW   = 2;

  // Action codes
  localparam logic [ActW-1:0] ActLoad   = 2'd0;
  localparam logic [ActW-1:0] ActEncode = 2'd1;
  localparam logic [ActW-1:0] ActFlush  = 2'd2;

  // Bijective run digits
  localparam logic [SymW-1:0] DigitOne = 8'hFD;
  localparam logic [SymW-1:0] DigitTwo = 8'hFE;

  // Reset value of the entry count
  localparam logic [CountW-1:0] CountReset = 9'd256;

  // Control broadcast from the sequencer to every list cell
  typedef struct packed {
    logic            capture;  // latch compare result against symbol
    logic            move;     // perform the move-to-front shift
    logic [SymW-1:0] symbol;   // compare symbol, load data or new front
  } cell_bcast_t;

endpackage

/* design/mtfzr_cell.sv */
// One list cell: holds an entry, compares it and shifts from its neighbor.
module mtfzr_cell (
  input  logic                      clk_i,
  input  mtfzr_pkg::cell_bcast_t    bcast_i,
  input  logic                      wr_en_i,
  input  logic                      search_en_i,
  input  logic [mtfzr_pkg::SymW-1:0] prev_i,
  input  logic                      seen_i,
  output logic [mtfzr_pkg::SymW-1:0] entry_o,
  output logic                      match_o,
  output logic                      seen_o,
  output logic                      first_o
);
  import mtfzr_pkg::*;

  logic [SymW-1:0] entry_q, entry_d;
  logic            match_q;
  logic            hit;

  // Flag a searchable hit and pass the prefix along the chain
  assign hit     = match_q & search_en_i;
  assign first_o = hit & ~seen_i;
  assign seen_o  = seen_i | hit;
  assign entry_o = entry_q;
  assign match_o = match_q;

  // Load, shift from the neighbor, or hold
  always_comb begin
    entry_d = entry_q;
    if (wr_en_i) begin
      entry_d = bcast_i.symbol;
    end else if (bcast_i.move && !seen_i) begin
      entry_d = prev_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    if (bcast_i.capture) begin
      match_q <= (entry_q == bcast_i.symbol);
    end
  end

endmodule

/* design/mtfzr_chain.sv */
// Row of list cells with prefix search and position encoder.
module mtfzr_chain #(
  parameter int unsigned LIST_DEPTH = mtfzr_pkg::DefListDepth
) (
  input  logic                         clk_i,
  input  mtfzr_pkg::cell_bcast_t       bcast_i,
  input  logic                         wr_en_i,
  input  logic [mtfzr_pkg::SymW-1:0]   wr_pos_i,
  input  logic [mtfzr_pkg::CountW-1:0] count_i,
  output logic                         front_hit_o,
  output logic                         found_o,
  output logic [mtfzr_pkg::SymW-1:0]   found_pos_o
);
  import mtfzr_pkg::*;

  logic [SymW-1:0]       entry [LIST_DEPTH];
  logic [LIST_DEPTH:0]   seen;
  logic [LIST_DEPTH-1:0] first;
  logic [LIST_DEPTH-1:0] match;

  assign seen[0] = 1'b0;

  for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
    localparam logic [SymW-1:0]   CellPos = SymW'(g);
    localparam logic [CountW-1:0] CellCnt = CountW'(g);
    logic            search_en;
    logic            wr_en;
    logic [SymW-1:0] prev;

    // Front cell only checks for a run; the rest search below the count
    assign search_en = (g != 0) && (CellCnt < count_i);
    assign wr_en     = wr_en_i && (wr_pos_i == CellPos);
    if (g == 0) begin : g_front
      assign prev = bcast_i.symbol;
    end else begin : g_body
      assign prev = entry[g-1];
    end

    mtfzr_cell u_cell (
      .clk_i       (clk_i),
      .bcast_i     (bcast_i),
      .wr_en_i     (wr_en),
      .search_en_i (search_en),
      .prev_i      (prev),
      .seen_i      (seen[g]),
      .entry_o     (entry[g]),
      .match_o     (match[g]),
      .seen_o      (seen[g+1]),
      .first_o     (first[g])
    );
  end

  assign front_hit_o = match[0];
  assign found_o     = seen[LIST_DEPTH];

  // Encode the one-hot first hit into its list position
  always_comb begin
    found_pos_o = '0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      if (first[i]) begin
        found_pos_o = found_pos_o | SymW'(i);
      end
    end
  end

endmodule

/* design/move_to_front_zero_run_coder.sv */
// Top level: sequencer, run counter and output register of the coder.
//
//   port group   direction  handshake              payload
//   in           sink       in_valid_i/in_stall_o  action_i, position_i, symbol_i
//   out          source     out_valid_o/out_stall_i code_o, error_o, end_of_block_o, last_o
//   cfg          sink       cfg_we_i               cfg_data_i (symbol_count)
//
// A load word emits no output. An encode word that hits the front entry ends
// after the decide state; otherwise, and for a flush word, the sequencer emits
// one word per run digit and then the closing word. The cell row compares all
// entries in the accept cycle and finds and shifts in the next one. Output
// stalls hold the sequencer. No clearing pass after reset; list entries are
// undefined until loaded.
module move_to_front_zero_run_coder #(
  parameter int unsigned LIST_DEPTH = mtfzr_pkg::DefListDepth,
  parameter int unsigned RUN_WIDTH  = mtfzr_pkg::DefRunWidth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [mtfzr_pkg::ActW-1:0]   action_i,
  input  logic [mtfzr_pkg::SymW-1:0]   position_i,
  input  logic [mtfzr_pkg::SymW-1:0]   symbol_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [mtfzr_pkg::SymW-1:0]   code_o,
  output logic                         error_o,
  output logic                         end_of_block_o,
  output logic                         last_o,
  input  logic                         cfg_we_i,
  input  logic [mtfzr_pkg::CountW-1:0] cfg_data_i
);
  import mtfzr_pkg::*;

  localparam logic [1:0] SIdle  = 2'd0;
  localparam logic [1:0] SDec   = 2'd1;
  localparam logic [1:0] SFlush = 2'd2;
  localparam logic [1:0] SRes   = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [CountW-1:0]    count_q;
  logic [RUN_WIDTH-1:0] run_q, run_d;
  logic [RUN_WIDTH-1:0] digit_q, digit_d;
  logic [ActW-1:0]      act_q;
  logic [SymW-1:0]      sym_q;
  logic [SymW-1:0]      res_code_q, res_code_d;
  logic                 res_err_q, res_err_d;
  logic                 res_eob_q, res_eob_d;

  logic                 out_valid_q, out_valid_d;
  logic [SymW-1:0]      code_q, code_d;
  logic                 error_q, error_d;
  logic                 eob_q, eob_d;
  logic                 last_q, last_d;

  logic                 accept;
  logic                 slot_free;
  logic                 front_hit;
  logic                 found;
  logic [SymW-1:0]      found_pos;
  cell_bcast_t          bcast;
  logic                 load_en;

  assign in_stall_o = (state_q != SIdle);
  assign accept     = in_valid_i && !in_stall_o;
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign load_en    = accept && (action_i == ActLoad)
                      && ({1'b0, position_i} < CountW'(LIST_DEPTH));

  // Drive the cell row
  always_comb begin
    bcast.capture = accept;
    bcast.move    = (state_q == SDec) && (act_q == ActEncode) && !front_hit && found;
    bcast.symbol  = (state_q == SIdle) ? symbol_i : sym_q;
  end

  mtfzr_chain #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_chain (
    .clk_i       (clk_i),
    .bcast_i     (bcast),
    .wr_en_i     (load_en),
    .wr_pos_i    (position_i),
    .count_i     (count_q),
    .front_hit_o (front_hit),
    .found_o     (found),
    .found_pos_o (found_pos)
  );

  // Sequence one word: decide, then, unless an encode hits the front, flush run digits and emit the closing word
  always_comb begin
    state_d     = state_q;
    run_d       = run_q;
    digit_d     = digit_q;
    res_code_d  = res_code_q;
    res_err_d   = res_err_q;
    res_eob_d   = res_eob_q;
    out_valid_d = out_valid_q && out_stall_i;
    code_d      = code_q;
    error_d     = error_q;
    eob_d       = eob_q;
    last_d      = last_q;
    case (state_q)
      SIdle: begin
        if (accept && (action_i == ActEncode || action_i == ActFlush)) begin
          state_d = SDec;
        end
      end
      SDec: begin
        if (act_q == ActEncode && front_hit) begin
          if (run_q != '1) begin
            run_d = run_q + RUN_WIDTH'(1);
          end
          state_d = SIdle;
        end else begin
          res_code_d = '0;
          res_err_d  = 1'b0;
          res_eob_d  = 1'b0;
          if (act_q == ActEncode) begin
            res_code_d = found ? found_pos : '0;
            res_err_d  = !found;
          end else begin
            res_eob_d = 1'b1;
          end
          digit_d = run_q - RUN_WIDTH'(1);
          run_d   = '0;
          state_d = (run_q != '0) ? SFlush : SRes;
        end
      end
      SFlush: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          code_d      = digit_q[0] ? DigitTwo : DigitOne;
          error_d     = 1'b0;
          eob_d       = 1'b0;
          last_d      = 1'b0;
          if (digit_q < RUN_WIDTH'(2)) begin
            state_d = SRes;
          end else begin
            digit_d = (digit_q - RUN_WIDTH'(2)) >> 1;
          end
        end
      end
      SRes: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          code_d      = res_code_q;
          error_d     = res_err_q;
          eob_d       = res_eob_q;
          last_d      = 1'b1;
          state_d     = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      count_q     <= CountReset;
      run_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      run_q       <= run_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        count_q <= cfg_data_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q <= action_i;
      sym_q <= symbol_i;
    end
    digit_q    <= digit_d;
    res_code_q <= res_code_d;
    res_err_q  <= res_err_d;
    res_eob_q  <= res_eob_d;
    code_q     <= code_d;
    error_q    <= error_d;
    eob_q      <= eob_d;
    last_q     <= last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign code_o         = code_q;
  assign error_o        = error_q;
  assign end_of_block_o = eob_q;
  assign last_o         = last_q;

  // Error and end marker words close their item and carry no code
  a_close_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (error_o || end_of_block_o) |-> last_o && code_o == '0)
    else $error("error or end marker word not closing its item");

  a_err_eob_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(error_o && end_of_block_o))
    else $error("error and end marker raised together");

  // Run is cleared once its digits are being emitted
  a_flush_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SFlush |-> run_q == '0)
    else $error("pending run not cleared during flush");

  // Encode and flush words hold off the input in the cycle after they are taken
  a_busy_after : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (action_i == ActEncode || action_i == ActFlush) |=> in_stall_o)
    else $error("input taken while a word is in progress");

endmodule
